FILE: sv/ubp_pkg.sv
// Shared constants, stage types and arithmetic steps for the unit ball projection pipeline.
package ubp_pkg;

    localparam int FRAC_BITS = 12;
    localparam int DATA_W    = 16;
    localparam int PROJ_W    = FRAC_BITS + 2;

    // one root bit per sqrt stage, one quotient bit per divide stage
    localparam int SQ_STEPS  = 16;
    localparam int D1_STEPS  = 19;
    localparam int D2_STEPS  = 22;
    localparam int LAT       = 2 + (SQ_STEPS + 1) + (D1_STEPS + 1) + (D2_STEPS + 1) + 1;

    localparam logic [31:0] ONE_SQ = 32'd1 << (2 * FRAC_BITS);
    localparam logic [21:0] POS_MAX = 22'd32767;
    localparam logic [21:0] NEG_MAX = 22'd32768;

    typedef struct packed {
        logic [31:0]        s;
        logic [16:0]        rem;
        logic [15:0]        root;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic               w_neg;
        logic [31:0]        w_mag;
        logic               scaled;
    } t_sq;

    typedef struct packed {
        logic [16:0]        r_px;
        logic [16:0]        r_py;
        logic [16:0]        r_a;
        logic [18:0]        q_px;
        logic [18:0]        q_py;
        logic [18:0]        q_a;
        logic [15:0]        n;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic               w_neg;
        logic               scaled;
    } t_d1;

    typedef struct packed {
        logic [16:0]        r_gx;
        logic [16:0]        r_gy;
        logic [21:0]        q_gx;
        logic [21:0]        q_gy;
        logic [15:0]        n;
        logic               gx_neg;
        logic               gy_neg;
        logic signed [13:0] px;
        logic signed [13:0] py;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic               scaled;
    } t_d2;

    // restoring square root step: {rem, root}
    function automatic logic [32:0] sqrt_step(input logic [16:0] rem, input logic [1:0] bits,
                                              input logic [15:0] root);
        logic [18:0] t;
        logic [18:0] trial;
        logic [18:0] diff;
        t     = {rem, bits};
        trial = {1'b0, root, 2'b01};
        diff  = t - trial;
        if (t >= trial) begin
            return {diff[16:0], root[14:0], 1'b1};
        end else begin
            return {t[16:0], root[14:0], 1'b0};
        end
    endfunction

    // restoring divide step: {rem, quotient bit}
    function automatic logic [17:0] div_step(input logic [16:0] r, input logic b,
                                             input logic [15:0] d);
        logic [17:0] t;
        logic [17:0] diff;
        t    = {r, b};
        diff = t - {2'b00, d};
        if (t >= {2'b00, d}) begin
            return {diff[16:0], 1'b1};
        end else begin
            return {t[16:0], 1'b0};
        end
    endfunction

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

endpackage

FILE: sv/unit_ball_projection_2d_unit.sv
// Projection of a 2-D vector onto the unit ball, with the projected gradient.
// Latency: 63 register stages from the input registers to the output registers.
// Throughput: one item per cycle while the output is not stalled; sqrt and both
// divides are bit-per-stage pipelines.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all stage valid bits; no clearing pass.
module unit_ball_projection_2d_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [ubp_pkg::DATA_W-1:0]     i_vec_x,
    input  logic signed [ubp_pkg::DATA_W-1:0]     i_vec_y,
    input  logic signed [ubp_pkg::DATA_W-1:0]     i_upstream_x,
    input  logic signed [ubp_pkg::DATA_W-1:0]     i_upstream_y,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [ubp_pkg::PROJ_W-1:0]     o_proj_x,
    output logic signed [ubp_pkg::PROJ_W-1:0]     o_proj_y,
    output logic signed [ubp_pkg::DATA_W-1:0]     o_grad_x,
    output logic signed [ubp_pkg::DATA_W-1:0]     o_grad_y,
    output logic                                  o_was_scaled
);
    import ubp_pkg::*;

    logic               en;
    logic [LAT-1:0]     r_vld;

    logic signed [15:0] r_x0, r_y0, r_ux0, r_uy0;
    logic [30:0]        r_xx, r_yy;
    logic signed [31:0] r_uxy, r_uyx;
    logic signed [15:0] r_x1, r_y1, r_ux1, r_uy1;

    t_sq r_sq [SQ_STEPS+1];
    t_sq n_sq [SQ_STEPS+1];
    t_d1 r_d1 [D1_STEPS+1];
    t_d1 n_d1 [D1_STEPS+1];
    t_d2 r_d2 [D2_STEPS+1];
    t_d2 n_d2 [D2_STEPS+1];

    logic signed [PROJ_W-1:0] r_px, r_py, n_px, n_py;
    logic signed [DATA_W-1:0] r_gx, r_gy, n_gx, n_gy;
    logic                     r_scaled;

    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // sqrt stages
    always_comb begin
        logic [31:0] s;
        logic signed [31:0] w;
        logic [32:0] st;
        s = {1'b0, r_xx} + {1'b0, r_yy};
        w = r_uxy - r_uyx;
        n_sq[0].s      = s;
        n_sq[0].rem    = '0;
        n_sq[0].root   = '0;
        n_sq[0].x      = r_x1;
        n_sq[0].y      = r_y1;
        n_sq[0].ux     = r_ux1;
        n_sq[0].uy     = r_uy1;
        n_sq[0].w_neg  = w[31];
        n_sq[0].w_mag  = w[31] ? 32'(-w) : 32'(w);
        n_sq[0].scaled = s > ONE_SQ;
        for (int k = 1; k <= SQ_STEPS; k++) begin
            n_sq[k]      = r_sq[k-1];
            st           = sqrt_step(r_sq[k-1].rem, r_sq[k-1].s[31:30], r_sq[k-1].root);
            n_sq[k].rem  = st[32:16];
            n_sq[k].root = st[15:0];
            n_sq[k].s    = {r_sq[k-1].s[29:0], 2'b00};
        end
    end

    // first divide group: x/n, y/n and w/n
    always_comb begin
        logic [27:0] nx, ny;
        logic [17:0] sx, sy, sa;
        nx = {mag16(r_sq[SQ_STEPS].x), 12'd0};
        ny = {mag16(r_sq[SQ_STEPS].y), 12'd0};
        n_d1[0].r_px   = {8'd0, nx[27:19]};
        n_d1[0].q_px   = nx[18:0];
        n_d1[0].r_py   = {8'd0, ny[27:19]};
        n_d1[0].q_py   = ny[18:0];
        n_d1[0].r_a    = {4'd0, r_sq[SQ_STEPS].w_mag[31:19]};
        n_d1[0].q_a    = r_sq[SQ_STEPS].w_mag[18:0];
        n_d1[0].n      = r_sq[SQ_STEPS].root;
        n_d1[0].x      = r_sq[SQ_STEPS].x;
        n_d1[0].y      = r_sq[SQ_STEPS].y;
        n_d1[0].ux     = r_sq[SQ_STEPS].ux;
        n_d1[0].uy     = r_sq[SQ_STEPS].uy;
        n_d1[0].w_neg  = r_sq[SQ_STEPS].w_neg;
        n_d1[0].scaled = r_sq[SQ_STEPS].scaled;
        for (int k = 1; k <= D1_STEPS; k++) begin
            n_d1[k]      = r_d1[k-1];
            sx           = div_step(r_d1[k-1].r_px, r_d1[k-1].q_px[18], r_d1[k-1].n);
            sy           = div_step(r_d1[k-1].r_py, r_d1[k-1].q_py[18], r_d1[k-1].n);
            sa           = div_step(r_d1[k-1].r_a,  r_d1[k-1].q_a[18],  r_d1[k-1].n);
            n_d1[k].r_px = sx[17:1];
            n_d1[k].q_px = {r_d1[k-1].q_px[17:0], sx[0]};
            n_d1[k].r_py = sy[17:1];
            n_d1[k].q_py = {r_d1[k-1].q_py[17:0], sy[0]};
            n_d1[k].r_a  = sa[17:1];
            n_d1[k].q_a  = {r_d1[k-1].q_a[17:0], sa[0]};
        end
    end

    // multiply by the other component, then second divide group
    always_comb begin
        t_d1 e;
        logic [34:0] mx, my;
        logic [13:0] qx, qy;
        logic [17:0] sx, sy;
        e  = r_d1[D1_STEPS];
        mx = e.q_a * mag16(e.y);
        my = e.q_a * mag16(e.x);
        qx = e.q_px[13:0];
        qy = e.q_py[13:0];
        n_d2[0].r_gx   = {4'd0, mx[34:22]};
        n_d2[0].q_gx   = mx[21:0];
        n_d2[0].r_gy   = {4'd0, my[34:22]};
        n_d2[0].q_gy   = my[21:0];
        n_d2[0].n      = e.n;
        n_d2[0].gx_neg = e.w_neg ^ e.y[15];
        n_d2[0].gy_neg = !(e.w_neg ^ e.x[15]);
        n_d2[0].px     = !e.scaled ? e.x[13:0] : (e.x[15] ? 14'(-qx) : qx);
        n_d2[0].py     = !e.scaled ? e.y[13:0] : (e.y[15] ? 14'(-qy) : qy);
        n_d2[0].ux     = e.ux;
        n_d2[0].uy     = e.uy;
        n_d2[0].scaled = e.scaled;
        for (int k = 1; k <= D2_STEPS; k++) begin
            n_d2[k]      = r_d2[k-1];
            sx           = div_step(r_d2[k-1].r_gx, r_d2[k-1].q_gx[21], r_d2[k-1].n);
            sy           = div_step(r_d2[k-1].r_gy, r_d2[k-1].q_gy[21], r_d2[k-1].n);
            n_d2[k].r_gx = sx[17:1];
            n_d2[k].q_gx = {r_d2[k-1].q_gx[20:0], sx[0]};
            n_d2[k].r_gy = sy[17:1];
            n_d2[k].q_gy = {r_d2[k-1].q_gy[20:0], sy[0]};
        end
    end

    // sign, saturation and passthrough select
    always_comb begin
        t_d2 e;
        logic signed [15:0] gx, gy;
        e = r_d2[D2_STEPS];
        if (e.gx_neg) begin
            gx = (e.q_gx >= NEG_MAX) ? 16'sh8000 : 16'(-e.q_gx);
        end else begin
            gx = (e.q_gx > POS_MAX) ? 16'sh7fff : 16'(e.q_gx);
        end
        if (e.gy_neg) begin
            gy = (e.q_gy >= NEG_MAX) ? 16'sh8000 : 16'(-e.q_gy);
        end else begin
            gy = (e.q_gy > POS_MAX) ? 16'sh7fff : 16'(e.q_gy);
        end
        n_px = e.px;
        n_py = e.py;
        n_gx = e.scaled ? gx : e.ux;
        n_gy = e.scaled ? gy : e.uy;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0  <= i_vec_x;
            r_y0  <= i_vec_y;
            r_ux0 <= i_upstream_x;
            r_uy0 <= i_upstream_y;
            r_xx  <= 31'(r_x0 * r_x0);
            r_yy  <= 31'(r_y0 * r_y0);
            r_uxy <= r_ux0 * r_y0;
            r_uyx <= r_uy0 * r_x0;
            r_x1  <= r_x0;
            r_y1  <= r_y0;
            r_ux1 <= r_ux0;
            r_uy1 <= r_uy0;
            r_sq  <= n_sq;
            r_d1  <= n_d1;
            r_d2  <= n_d2;
            r_px  <= n_px;
            r_py  <= n_py;
            r_gx  <= n_gx;
            r_gy  <= n_gy;
            r_scaled <= r_d2[D2_STEPS].scaled;
        end
    end

    assign o_proj_x     = r_px;
    assign o_proj_y     = r_py;
    assign o_grad_x     = r_gx;
    assign o_grad_y     = r_gy;
    assign o_was_scaled = r_scaled;

endmodule

FILE: sv/ubp_checker.sv
// Port-level assertions for the unit ball projection block, bound to the top level.
module ubp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic signed [ubp_pkg::DATA_W-1:0] i_vec_x,
    input logic signed [ubp_pkg::DATA_W-1:0] i_vec_y,
    input logic signed [ubp_pkg::DATA_W-1:0] i_upstream_x,
    input logic signed [ubp_pkg::DATA_W-1:0] i_upstream_y,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic signed [ubp_pkg::PROJ_W-1:0] o_proj_x,
    input logic signed [ubp_pkg::PROJ_W-1:0] o_proj_y,
    input logic signed [ubp_pkg::DATA_W-1:0] o_grad_x,
    input logic signed [ubp_pkg::DATA_W-1:0] o_grad_y,
    input logic                              o_was_scaled
);
    import ubp_pkg::*;

    // held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_proj_x) && $stable(o_proj_y)
            && $stable(o_grad_x) && $stable(o_grad_y) && $stable(o_was_scaled))
        else $error("output item changed while stalled");

    // pipeline advances exactly when the output slot is free
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output slot");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_proj_x <= 14'sd4096 && o_proj_x >= -14'sd4096
            && o_proj_y <= 14'sd4096 && o_proj_y >= -14'sd4096)
        else $error("projected component above unit magnitude");

    // a scaled vector has norm above one, so its projection is never zero
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_scaled |-> o_proj_x != 0 || o_proj_y != 0)
        else $error("scaled item projected to zero");

endmodule

bind unit_ball_projection_2d_unit ubp_checker u_ubp_checker (.*);
